[src/stpr_pkg.sv]
// ----------------------------------------------------------------------------
// Stepper ramp package
// Shared types, command codes and fixed constants of the stepper ramp block.
// ----------------------------------------------------------------------------
package stpr_pkg;

    // Period format is unsigned 24.16 fixed point.
    localparam int PW  = 40;
    localparam int NW  = 16;
    // Serial divider operand widths.
    localparam int DVN = 58;
    localparam int DVD = 32;

    localparam logic [PW-1:0] PMAX = {PW{1'b1}};

    // Register reset values.
    localparam logic [15:0] IP_RST  = 16'd25000;
    localparam logic [26:0] CF_RST  = 27'd2048780;
    localparam logic [15:0] SPR_RST = 16'd3200;

    // Ramp constants.
    localparam logic [15:0] NEAR_OFS = 16'd100;
    localparam logic [15:0] MIN_INT  = 16'd11;
    localparam logic [15:0] MAX_INT  = 16'd65535;
    // Seconds per minute times sixteen quarter-steps of the speed unit.
    localparam logic [9:0]  SEC_Q4   = 10'd960;

    typedef enum logic [1:0] {
        CMD_SET     = 2'd0,
        CMD_STEP    = 2'd1,
        CMD_ENABLE  = 2'd2,
        CMD_DISABLE = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_SET,
        OP_DEC,
        OP_LEN
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_MUL,
        S_LOAD,
        S_DIV,
        S_WB,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        REG_INIT_PERIOD   = 2'd0,
        REG_COUNTER_FREQ  = 2'd1,
        REG_STEPS_PER_REV = 2'd2
    } t_reg;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;
        logic eval;
        logic mul;
        logic div_start;
        logic wb;
        logic emit;
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic need_div;
        logic div_busy;
        logic out_free;
    } t_dp_sts;

endpackage

[src/stpr_div.sv]
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned divider, one quotient bit per cycle. A zero divisor
// gives an all-ones quotient.
// ----------------------------------------------------------------------------
module stpr_div #(
    parameter int WN = 58,
    parameter int WD = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [WN-1:0] i_dividend,
    input  logic [WD-1:0] i_divisor,
    output logic          o_busy,
    output logic [WN-1:0] o_quotient
);

    localparam int CW = $clog2(WN + 1);

    logic [WN-1:0] r_quo;
    logic [WD-1:0] r_rem;
    logic [WD-1:0] r_div;
    logic [CW-1:0] r_cnt;
    logic          r_busy;

    logic [WD:0]   w_sh;
    logic [WD:0]   w_diff;
    logic          w_ge;

    // One trial subtraction per cycle.
    always_comb begin
        w_sh   = {r_rem, r_quo[WN-1]};
        w_ge   = (w_sh >= {1'b0, r_div});
        w_diff = w_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(WN);
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[WD-1:0] : w_sh[WD-1:0];
            r_quo <= {r_quo[WN-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule

[src/stpr_dp.sv]
// ----------------------------------------------------------------------------
// Stepper ramp datapath
// Per-motor ramp state, step and set evaluation, operand products, the
// shared serial divider and the result register.
// ----------------------------------------------------------------------------
module stpr_dp import stpr_pkg::*; #(
    parameter int MOTOR_COUNT = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_dp_cmd       i_ctl,
    output t_dp_sts       o_sts,
    input  logic [1:0]    i_cmd,
    input  logic [1:0]    i_motor,
    input  logic [15:0]   i_rpm_q4,
    input  logic [15:0]   i_init_period,
    input  logic [26:0]   i_counter_freq,
    input  logic [15:0]   i_steps_per_rev,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output logic [1:0]    o_motor_out,
    output logic [15:0]   o_reload_period,
    output logic          o_timer_run,
    output logic          o_dir_level,
    output logic          o_driver_enable
);

    localparam int IW = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

    // Per-motor state.
    logic [PW-1:0] r_pn [MOTOR_COUNT];
    logic [NW-1:0] r_ri [MOTOR_COUNT];
    logic [PW-1:0] r_pt [MOTOR_COUNT];
    logic          r_dt [MOTOR_COUNT];
    logic          r_dn [MOTOR_COUNT];
    logic          r_sw [MOTOR_COUNT];
    logic          r_to [MOTOR_COUNT];
    logic          r_pl [MOTOR_COUNT];
    logic          r_drv;

    // Captured item and working values.
    logic [1:0]     r_cmd;
    logic [1:0]     r_motor;
    logic [15:0]    r_rpm;
    t_op            r_op;
    logic           r_upd;
    logic [PW-1:0]  r_p;
    logic [NW-1:0]  r_n;
    logic           r_tmr;
    logic           r_pin;
    logic           r_dnw;
    logic           r_dtw;
    logic           r_stop;
    logic [DVN-1:0] r_dividend;
    logic [DVD-1:0] r_divisor;

    // Result register.
    logic           r_out_valid;
    logic [1:0]     r_o_motor;
    logic [15:0]    r_o_reload;
    logic           r_o_run;
    logic           r_o_dir;
    logic           r_o_drv;

    logic           w_valid;
    logic [IW-1:0]  w_idx;
    logic [PW-1:0]  w_ip;
    logic [PW-1:0]  w_near;
    logic           w_near_neg;
    logic           w_busy;
    logic [DVN-1:0] w_quo;
    logic [PW-1:0]  w_qsat;
    logic [15:0]    w_mag;

    // Eval outputs.
    t_op            v_op;
    logic           v_upd;
    logic [PW-1:0]  v_p;
    logic [NW-1:0]  v_n;
    logic           v_tmr;
    logic           v_pin;
    logic           v_dn;
    logic           v_dt;
    logic           v_stop;

    // Writeback values.
    logic [PW-1:0]  f_p;
    logic [NW-1:0]  f_n;
    logic           f_tmr;
    logic [PW-1:0]  f_tgt;

    logic [36:0]    w_cf960;
    logic [DVN-1:0] w_prod_len;

    // Common decode of the captured item.
    always_comb begin
        w_valid    = (32'(r_motor) < MOTOR_COUNT);
        w_idx      = w_valid ? IW'(r_motor) : '0;
        w_ip       = {8'd0, i_init_period, 16'd0};
        w_near_neg = (i_init_period < NEAR_OFS);
        w_near     = {8'd0, i_init_period - NEAR_OFS, 16'd0};
        w_mag      = r_rpm[15] ? (16'd0 - r_rpm) : r_rpm;
        w_qsat     = (|w_quo[DVN-1:PW]) ? PMAX : w_quo[PW-1:0];
    end

    // Step and set evaluation on the addressed motor.
    always_comb begin
        v_op   = OP_NONE;
        v_upd  = 1'b0;
        v_p    = r_pn[w_idx];
        v_n    = r_ri[w_idx];
        v_tmr  = r_to[w_idx];
        v_pin  = r_pl[w_idx];
        v_dn   = r_dn[w_idx];
        v_dt   = r_dt[w_idx];
        v_stop = 1'b0;
        priority if (r_cmd == CMD_STEP && w_valid && r_to[w_idx]) begin
            v_upd = 1'b1;
            // A pending stop near the start period halts the timer.
            if (r_sw[w_idx] && (w_near_neg || v_p >= w_near)) begin
                v_tmr = 1'b0;
                v_p   = w_ip;
                v_n   = '0;
            end
            if (r_dt[w_idx] == r_dn[w_idx]) begin
                if (v_p >= w_ip) begin
                    v_p = w_ip;
                    v_n = '0;
                end
                if (r_pt[w_idx] >= w_ip && (w_near_neg || v_p >= w_near)) begin
                    v_p = r_pt[w_idx];
                    v_n = '0;
                end else if (v_p > r_pt[w_idx]) begin
                    if (v_n != {NW{1'b1}}) begin
                        v_n = v_n + 1'b1;
                    end
                    v_op = OP_DEC;
                end else if (v_n != '0) begin
                    v_op = OP_LEN;
                end
            end else begin
                // Reverse only once the period is back near the start period.
                if (w_near_neg || v_p > w_near) begin
                    v_pin = ~r_dt[w_idx];
                    v_dn  = r_dt[w_idx];
                    v_p   = w_ip;
                    v_n   = '0;
                end else if (v_n != '0) begin
                    v_op = OP_LEN;
                end
            end
        end else if (r_cmd == CMD_SET && w_valid && r_drv) begin
            v_upd = 1'b1;
            if (r_rpm == 16'd0) begin
                v_stop = 1'b1;
            end else begin
                v_dt = r_rpm[15];
                v_op = OP_SET;
            end
        end else begin
            v_upd = 1'b0;
        end
    end

    // Divider operand products.
    always_comb begin
        w_cf960    = 37'(i_counter_freq) * 37'(SEC_Q4);
        w_prod_len = DVN'(r_p) * DVN'({r_n, 2'b01});
    end

    // Final period after the divider and the range clamps.
    always_comb begin
        f_p   = r_p;
        f_n   = r_n;
        f_tmr = r_tmr;
        f_tgt = r_stop ? w_ip : w_qsat;
        unique case (r_op)
            OP_DEC: f_p = r_p - w_quo[PW-1:0];
            OP_LEN: begin
                f_p = w_qsat;
                f_n = r_n - 1'b1;
            end
            default: f_p = r_p;
        endcase
        if (f_p < {8'd0, MIN_INT, 16'd0}) begin
            f_p = {8'd0, MIN_INT, 16'd0};
        end
        if (f_p > {8'd0, MAX_INT, 16'd0}) begin
            f_tmr = 1'b0;
            f_p   = w_ip;
            f_n   = '0;
        end
    end

    // Capture, evaluation and operand registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op  <= OP_NONE;
            r_upd <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_cmd   <= i_cmd;
                r_motor <= i_motor;
                r_rpm   <= i_rpm_q4;
            end
            if (i_ctl.eval) begin
                r_op   <= v_op;
                r_upd  <= v_upd;
                r_p    <= v_p;
                r_n    <= v_n;
                r_tmr  <= v_tmr;
                r_pin  <= v_pin;
                r_dnw  <= v_dn;
                r_dtw  <= v_dt;
                r_stop <= v_stop;
            end
            if (i_ctl.mul) begin
                unique case (r_op)
                    OP_SET: begin
                        r_dividend <= DVN'({w_cf960, 16'd0});
                        r_divisor  <= 32'(i_steps_per_rev) * 32'(w_mag);
                    end
                    OP_DEC: begin
                        r_dividend <= DVN'({r_p, 1'b0});
                        r_divisor  <= DVD'({r_n, 2'b01});
                    end
                    OP_LEN: begin
                        r_dividend <= w_prod_len;
                        r_divisor  <= DVD'({r_n - 1'b1, 2'b11});
                    end
                    default: begin
                        r_dividend <= '0;
                        r_divisor  <= '0;
                    end
                endcase
            end
        end
    end

    // Per-motor state update.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                r_pn[m] <= {8'd0, IP_RST, 16'd0};
                r_ri[m] <= '0;
                r_pt[m] <= '0;
                r_dt[m] <= 1'b1;
                r_dn[m] <= 1'b1;
                r_sw[m] <= 1'b0;
                r_to[m] <= 1'b0;
                r_pl[m] <= 1'b0;
            end
            r_drv <= 1'b0;
        end else if (i_ctl.wb) begin
            unique case (r_cmd)
                CMD_STEP: begin
                    if (r_upd) begin
                        r_pn[w_idx] <= f_p;
                        r_ri[w_idx] <= f_n;
                        r_to[w_idx] <= f_tmr;
                        r_pl[w_idx] <= r_pin;
                        r_dn[w_idx] <= r_dnw;
                    end
                end
                CMD_SET: begin
                    if (r_upd) begin
                        r_sw[w_idx] <= r_stop;
                        r_pt[w_idx] <= f_tgt;
                        if (!r_stop) begin
                            r_dt[w_idx] <= r_dtw;
                            r_to[w_idx] <= 1'b1;
                        end
                    end
                end
                CMD_ENABLE: r_drv <= 1'b1;
                default: begin
                    for (int m = 0; m < MOTOR_COUNT; m++) begin
                        r_to[m] <= 1'b0;
                        r_pn[m] <= w_ip;
                        r_ri[m] <= '0;
                    end
                    r_drv <= 1'b0;
                end
            endcase
        end
    end

    // Result register; a waiting result does not hold up new work.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.emit) begin
            r_out_valid <= 1'b1;
            r_o_motor   <= r_motor;
            r_o_reload  <= w_valid ? r_pn[w_idx][31:16] : 16'd0;
            r_o_run     <= w_valid & r_to[w_idx];
            r_o_dir     <= w_valid & r_pl[w_idx];
            r_o_drv     <= r_drv;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    stpr_div #(
        .WN(DVN),
        .WD(DVD)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_ctl.div_start),
        .i_dividend (r_dividend),
        .i_divisor  (r_divisor),
        .o_busy     (w_busy),
        .o_quotient (w_quo)
    );

    always_comb begin
        o_sts.need_div = (r_op != OP_NONE);
        o_sts.div_busy = w_busy;
        o_sts.out_free = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid     = r_out_valid;
    assign o_motor_out     = r_o_motor;
    assign o_reload_period = r_o_reload;
    assign o_timer_run     = r_o_run;
    assign o_dir_level     = r_o_dir;
    assign o_driver_enable = r_o_drv;

endmodule

[src/stpr_ctrl.sv]
// ----------------------------------------------------------------------------
// Stepper ramp controller
// Sequences capture, evaluation, operand setup, division, writeback and
// result transfer for one item at a time.
// ----------------------------------------------------------------------------
module stpr_ctrl import stpr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_ctl
);

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_ctl      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_ctl.load = 1'b1;
                    n_state    = S_EVAL;
                end
            end
            S_EVAL: begin
                o_ctl.eval = 1'b1;
                n_state    = S_MUL;
            end
            S_MUL: begin
                o_ctl.mul = 1'b1;
                n_state   = i_sts.need_div ? S_LOAD : S_WB;
            end
            S_LOAD: begin
                o_ctl.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_WB;
                end
            end
            S_WB: begin
                o_ctl.wb = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

[src/stepper_ramp_controller.sv]
// ----------------------------------------------------------------------------
// Stepper ramp controller top level
// Three-motor linear step-period ramp with APB configuration registers.
//
//   Channel   Direction  Handshake                 Payload
//   input     in         i_in_valid / o_in_stall   i_cmd, i_motor, i_rpm_q4
//   output    out        o_out_valid / i_out_stall o_motor_out, o_reload_period,
//                                                  o_timer_run, o_dir_level,
//                                                  o_driver_enable
//   config    in         psel / penable / pready   paddr, pwdata, prdata
//
// An item that needs a division (set with nonzero speed, or a ramp step that
// accelerates or decelerates) passes through the 58-bit serial divider;
// every other item goes from operand setup straight to writeback.
// One item is in work at a time; the next is taken while a result waits.
// Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module stepper_ramp_controller import stpr_pkg::*; #(
    parameter int MOTOR_COUNT = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [1:0]  i_motor,
    input  logic [15:0] i_rpm_q4,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_motor_out,
    output logic [15:0] o_reload_period,
    output logic        o_timer_run,
    output logic        o_dir_level,
    output logic        o_driver_enable,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] r_init_period;
    logic [26:0] r_counter_freq;
    logic [15:0] r_steps_per_rev;
    t_reg        w_reg;
    t_dp_cmd     w_ctl;
    t_dp_sts     w_sts;

    assign w_reg  = t_reg'(paddr[3:2]);
    assign pready = 1'b1;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_period   <= IP_RST;
            r_counter_freq  <= CF_RST;
            r_steps_per_rev <= SPR_RST;
        end else if (psel && penable && pwrite) begin
            unique case (w_reg)
                REG_INIT_PERIOD:   r_init_period   <= pwdata[15:0];
                REG_COUNTER_FREQ:  r_counter_freq  <= pwdata[26:0];
                REG_STEPS_PER_REV: r_steps_per_rev <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Configuration readback.
    always_comb begin
        unique case (w_reg)
            REG_INIT_PERIOD:   prdata = {16'd0, r_init_period};
            REG_COUNTER_FREQ:  prdata = {5'd0, r_counter_freq};
            REG_STEPS_PER_REV: prdata = {16'd0, r_steps_per_rev};
            default:           prdata = 32'd0;
        endcase
    end

    stpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (w_sts),
        .o_ctl      (w_ctl)
    );

    stpr_dp #(
        .MOTOR_COUNT(MOTOR_COUNT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .o_sts           (w_sts),
        .i_cmd           (i_cmd),
        .i_motor         (i_motor),
        .i_rpm_q4        (i_rpm_q4),
        .i_init_period   (r_init_period),
        .i_counter_freq  (r_counter_freq),
        .i_steps_per_rev (r_steps_per_rev),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_motor_out     (o_motor_out),
        .o_reload_period (o_reload_period),
        .o_timer_run     (o_timer_run),
        .o_dir_level     (o_dir_level),
        .o_driver_enable (o_driver_enable)
    );

endmodule

[src/stpr_chk.sv]
// ----------------------------------------------------------------------------
// Stepper ramp port checker
// Assertions on the top-level ports, attached by a bind statement.
// ----------------------------------------------------------------------------
module stpr_chk #(
    parameter int MOTOR_COUNT = 3
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_motor_out,
    input logic [15:0] o_reload_period,
    input logic        o_timer_run,
    input logic        o_dir_level,
    input logic        o_driver_enable
);

    // A stalled result stays and holds its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_reload_period)
            && $stable(o_motor_out))
        else $error("result changed while stalled");

    // Each accepted transfer keeps the input stalled while it is worked on.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted back to back");

    // A motor index outside the range reports zeros.
    a_bad_motor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (32'(o_motor_out) >= MOTOR_COUNT)
            |-> (o_reload_period == 16'd0) && !o_timer_run && !o_dir_level)
        else $error("nonzero result for absent motor");

    // No step timer runs while the drivers are off.
    a_drv_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_driver_enable |-> !o_timer_run)
        else $error("timer runs with drivers disabled");

endmodule

bind stepper_ramp_controller stpr_chk #(.MOTOR_COUNT(MOTOR_COUNT)) u_chk (.*);

[tb/stpr_ramp_checker.sv]
// ----------------------------------------------------------------------------
// Stepper ramp checker
// Watches the command, result and configuration buses of the stepper ramp
// block, predicts every result from its own copy of the ramp state, and
// compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module stpr_ramp_checker import stpr_pkg::*; #(
    parameter int MOTOR_COUNT = 3
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_cmd,
    input  logic [1:0]  i_motor,
    input  logic [15:0] i_rpm_q4,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [1:0]  i_motor_out,
    input  logic [15:0] i_reload_period,
    input  logic        i_timer_run,
    input  logic        i_dir_level,
    input  logic        i_driver_enable,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [3:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    typedef struct packed {
        logic [1:0]  motor;
        logic [15:0] reload;
        logic        run;
        logic        dir;
        logic        drv;
    } t_ramp_result;

    localparam logic [63:0] FULL = 64'hFF_FFFF_FFFF;
    localparam logic [63:0] ONE  = 64'd65536;

    // Shadow copy of the configuration and the per-motor ramp state.
    logic [15:0] cfg_ip;
    logic [26:0] cfg_cf;
    logic [15:0] cfg_spr;
    logic [63:0] per_now  [MOTOR_COUNT];
    logic [15:0] ramp_n   [MOTOR_COUNT];
    logic [63:0] per_goal [MOTOR_COUNT];
    logic        dir_goal [MOTOR_COUNT];
    logic        dir_cur  [MOTOR_COUNT];
    logic        stop_req [MOTOR_COUNT];
    logic        run      [MOTOR_COUNT];
    logic        pin      [MOTOR_COUNT];
    logic        drv_on;

    t_ramp_result awaited[$];
    int fails;

    assign o_fail_count = fails;
    assign o_pending    = awaited.size();

    function automatic logic [63:0] slow_down(logic [63:0] p, logic [15:0] n);
        logic [63:0] q;
        q = (p * (4 * 64'(n) + 1)) / (4 * 64'(n) - 1);
        return (q > FULL) ? FULL : q;
    endfunction

    task automatic halt_all();
        for (int m = 0; m < MOTOR_COUNT; m++) begin
            run[m]     = 1'b0;
            per_now[m] = 64'(cfg_ip) * ONE;
            ramp_n[m]  = '0;
        end
    endtask

    task automatic apply_set(int m, logic [15:0] raw);
        int          spd;
        logic [63:0] mag, num, den, q;
        spd = -int'($signed(raw));
        if (!drv_on) return;
        if (spd == 0) begin
            stop_req[m] = 1'b1;
            per_goal[m] = 64'(cfg_ip) * ONE;
            return;
        end
        stop_req[m] = 1'b0;
        dir_goal[m] = (spd > 0);
        mag = (spd > 0) ? 64'(spd) : 64'(-spd);
        num = (64'(cfg_cf) * 960) << 16;
        den = 64'(cfg_spr) * mag;
        if (den == 0) q = FULL;
        else begin
            q = num / den;
            if (q > FULL) q = FULL;
        end
        per_goal[m] = q;
        run[m] = 1'b1;
    endtask

    task automatic apply_step(int m);
        logic [63:0] ip, p, t;
        logic [15:0] n;
        longint      near;
        ip   = 64'(cfg_ip) * ONE;
        near = (longint'(cfg_ip) - 100) * 65536;
        p = per_now[m];
        n = ramp_n[m];
        t = per_goal[m];
        if (!run[m]) return;
        // A pending stop takes effect once the period is back near its start.
        if (stop_req[m] && longint'(p) >= near) begin
            run[m] = 1'b0;
            p = ip;
            n = '0;
        end
        if (dir_goal[m] == dir_cur[m]) begin
            if (p >= ip) begin
                p = ip;
                n = '0;
            end
            if (t >= ip && longint'(p) >= near) begin
                p = t;
                n = '0;
            end else if (p > t) begin
                if (n != 16'hFFFF) n = n + 1;
                p = p - (2 * p) / (4 * 64'(n) + 1);
            end else if (n != 0) begin
                p = slow_down(p, n);
                n = n - 1;
            end
        end else begin
            // Reverse only when slow enough, otherwise keep decelerating.
            if (longint'(p) > near) begin
                pin[m]     = ~dir_goal[m];
                dir_cur[m] = dir_goal[m];
                p = ip;
                n = '0;
            end else if (n != 0) begin
                p = slow_down(p, n);
                n = n - 1;
            end
        end
        if (p < 11 * ONE) p = 11 * ONE;
        if (p > 65535 * ONE) begin
            run[m] = 1'b0;
            p = ip;
            n = '0;
        end
        per_now[m] = p;
        ramp_n[m]  = n;
    endtask

    task automatic predict_result(logic [1:0] cmd, logic [1:0] motor, logic [15:0] raw);
        t_ramp_result r;
        int           m;
        logic         ok;
        m  = int'(motor);
        ok = (m < MOTOR_COUNT);
        case (t_cmd'(cmd))
            CMD_SET:    if (ok) apply_set(m, raw);
            CMD_STEP:   if (ok) apply_step(m);
            CMD_ENABLE: drv_on = 1'b1;
            default: begin
                halt_all();
                drv_on = 1'b0;
            end
        endcase
        r.motor  = motor;
        r.reload = ok ? per_now[m][31:16] : '0;
        r.run    = ok ? run[m] : 1'b0;
        r.dir    = ok ? pin[m] : 1'b0;
        r.drv    = drv_on;
        awaited.push_back(r);
    endtask

    task automatic report(string what, int got, int want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fails++;
    endtask

    // Every transfer on the three buses is handled at the rising edge.
    always @(posedge i_clk) begin
        t_ramp_result e;
        if (!i_rst_n) begin
            cfg_ip  = IP_RST;
            cfg_cf  = CF_RST;
            cfg_spr = SPR_RST;
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                per_goal[m] = '0;
                dir_goal[m] = 1'b1;
                dir_cur[m]  = 1'b1;
                stop_req[m] = 1'b0;
                pin[m]      = 1'b0;
            end
            halt_all();
            drv_on = 1'b0;
            awaited.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg'(i_paddr[3:2]))
                    REG_INIT_PERIOD:   cfg_ip  = i_pwdata[15:0];
                    REG_COUNTER_FREQ:  cfg_cf  = i_pwdata[26:0];
                    REG_STEPS_PER_REV: cfg_spr = i_pwdata[15:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (awaited.size() == 0) begin
                    report("unexpected result, motor", i_motor_out, 0);
                end else begin
                    e = awaited.pop_front();
                    if (i_motor_out != e.motor) report("motor_out", i_motor_out, e.motor);
                    if (i_reload_period != e.reload)
                        report("reload_period", i_reload_period, e.reload);
                    if (i_timer_run != e.run) report("timer_run", i_timer_run, e.run);
                    if (i_dir_level != e.dir) report("dir_level", i_dir_level, e.dir);
                    if (i_driver_enable != e.drv)
                        report("driver_enable", i_driver_enable, e.drv);
                end
            end
            if (i_in_valid && !i_in_stall) predict_result(i_cmd, i_motor, i_rpm_q4);
        end
    end

endmodule

[tb/tb_stepper_ramp_controller.sv]
// ----------------------------------------------------------------------------
// Stepper ramp controller testbench
// Drives directed and random command streams with random idle gaps on both
// channels, across several register settings, and takes the verdict from
// the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_stepper_ramp_controller;
    import stpr_pkg::*;

    localparam int WATCH_LIMIT = 3000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_cmd = '0;
    logic [1:0]  i_motor = '0;
    logic [15:0] i_rpm_q4 = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [1:0]  o_motor_out;
    logic [15:0] o_reload_period;
    logic        o_timer_run;
    logic        o_dir_level;
    logic        o_driver_enable;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int idle_cycles = 0;
    int out_hold = 0;
    logic out_fire = 1'b0;
    logic calm = 1'b0;

    stepper_ramp_controller i_dut (.*);

    stpr_ramp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall),
        .i_cmd(i_cmd), .i_motor(i_motor), .i_rpm_q4(i_rpm_q4),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .i_motor_out(o_motor_out), .i_reload_period(o_reload_period),
        .i_timer_run(o_timer_run), .i_dir_level(o_dir_level),
        .i_driver_enable(o_driver_enable),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_paddr(paddr), .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // After each accepted result the receiver stalls at random, except in calm phases.
    always @(posedge i_clk) out_fire <= o_out_valid & ~i_out_stall;

    always @(negedge i_clk) begin
        if (out_fire) out_hold = calm ? 0 : $urandom_range(0, 4);
        i_out_stall = (out_hold > 0);
        if (out_hold > 0) out_hold--;
    end

    // The watchdog ends a run in which no transfer happens for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic reg_write(t_reg idx, logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    // One command transfer, preceded by a random idle gap.
    task automatic send(t_cmd cmd, logic [1:0] motor, logic [15:0] rpm);
        int   gap;
        logic stalled;
        gap = calm ? 0 : $urandom_range(0, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            @(negedge i_clk);
        end
        i_cmd = cmd;
        i_motor = motor;
        i_rpm_q4 = rpm;
        i_in_valid = 1'b1;
        forever begin
            #1 stalled = o_in_stall;
            @(posedge i_clk);
            if (!stalled) break;
            @(negedge i_clk);
        end
    endtask

    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (80) @(negedge i_clk);
    endtask

    task automatic configure(logic [15:0] ip, logic [26:0] cf, logic [15:0] spr);
        settle();
        reg_write(REG_INIT_PERIOD, 32'(ip));
        reg_write(REG_COUNTER_FREQ, 32'(cf));
        reg_write(REG_STEPS_PER_REV, 32'(spr));
    endtask

    function automatic logic [15:0] pick_speed();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r < 3) return 16'($urandom);
        if (r < 6) return 16'($urandom_range(1, 4000));
        return -16'($urandom_range(1, 4000));
    endfunction

    // Mostly ramp steps with some sets; the rest is enables and disables.
    task automatic random_phase(int count);
        int          r;
        logic [1:0]  m;
        calm = ($urandom_range(0, 3) == 0);
        send(CMD_ENABLE, 2'($urandom_range(0, 3)), 16'($urandom));
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(0, 99);
            m = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
            if (r < 12) send(CMD_SET, m, pick_speed());
            else if (r < 92) send(CMD_STEP, m, 16'($urandom));
            else if (r < 96) send(CMD_ENABLE, m, 16'($urandom));
            else send(CMD_DISABLE, m, 16'($urandom));
        end
        calm = 1'b0;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: disabled set, enable, speed extremes, stop, bad motor.
        send(CMD_STEP, 2'd0, 16'h0000);
        send(CMD_SET, 2'd0, 16'h0640);
        send(CMD_ENABLE, 2'd1, 16'hFFFF);
        send(CMD_STEP, 2'd2, 16'h0000);
        send(CMD_SET, 2'd0, 16'h7FFF);
        send(CMD_SET, 2'd1, 16'h8000);
        send(CMD_SET, 2'd2, 16'h0001);
        send(CMD_STEP, 2'd0, 16'h0000);
        send(CMD_STEP, 2'd1, 16'h0000);
        send(CMD_STEP, 2'd2, 16'h0000);
        send(CMD_STEP, 2'd0, 16'h0000);
        send(CMD_SET, 2'd0, 16'hFFFF);
        send(CMD_STEP, 2'd0, 16'h0000);
        send(CMD_SET, 2'd0, 16'h0000);
        send(CMD_STEP, 2'd0, 16'h0000);
        send(CMD_STEP, 2'd0, 16'h0000);
        send(CMD_SET, 2'd3, 16'h1234);
        send(CMD_STEP, 2'd3, 16'h0000);
        send(CMD_DISABLE, 2'd3, 16'h0000);
        send(CMD_SET, 2'd1, 16'h0100);
        send(CMD_STEP, 2'd1, 16'h0000);

        random_phase(200);
        configure(16'd1000, 27'd2048780, 16'd3200);
        random_phase(180);
        configure(16'd200, 27'd100000000, 16'd65535);
        random_phase(150);
        configure(16'd65535, 27'd1, 16'd1);
        random_phase(150);
        configure(16'd50, 27'd2048780, 16'd0);
        random_phase(120);
        configure(16'd300, 27'h7FFFFFF, 16'hFFFF);
        random_phase(150);
        configure(16'($urandom_range(200, 3000)), 27'($urandom_range(100000, 5000000)),
                  16'($urandom_range(100, 4000)));
        random_phase(150);

        settle();
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
